@@ design/bold_pkg.sv @@
// Shared constants, codes, command/status types and width helpers for the list deque.
package bold_pkg;

  // Storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = $clog2(DEPTH);

  // Fixed port field widths
  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 5;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ_FWD   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_BWD   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic              exec;     // single-result operation, taken this cycle
    logic [MODE_W-1:0] mode;
    logic              rd_load;  // load one traversal entry into the output stage
    logic [IDX_W-1:0]  rd_idx;
    logic              rd_last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             slot_free; // output stage can take a result this cycle
    logic [CNT_W-1:0] count;
  } stat_t;

  // Input value to cell width (zero-extend or truncate)
  function automatic logic [DATA_WIDTH-1:0] to_cell(input logic [VALUE_W-1:0] v);
    logic [127:0] w;
    w = 128'(v);
    return w[DATA_WIDTH-1:0];
  endfunction

  // Cell to output width (zero-extend or truncate)
  function automatic logic [VALUE_W-1:0] from_cell(input logic [DATA_WIDTH-1:0] c);
    logic [127:0] w;
    w = 128'(c);
    return w[VALUE_W-1:0];
  endfunction

endpackage

@@ design/bold_if.sv @@
// Valid/ready channel interfaces for operation items and result items.
interface bold_in_if;
  import bold_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

interface bold_out_if;
  import bold_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  data_value;
  logic                       is_last;
  logic [STATUS_W-1:0]        status;
  logic [ENTRY_W-1:0]         entry_count;

  modport source (output valid, data_value, is_last, status, entry_count, input ready);
  modport sink   (input valid, data_value, is_last, status, entry_count, output ready);
endinterface

@@ design/bold_ctrl.sv @@
// Controller: accepts operations and sequences traversal read-outs one entry per transfer.
module bold_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [bold_pkg::MODE_W-1:0] in_mode,
  output logic                        in_ready,
  input  bold_pkg::stat_t             stat,
  output bold_pkg::cmd_t              cmd
);
  import bold_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic             state, state_next;
  logic             backward, backward_next;
  logic [IDX_W-1:0] rd_i, rd_i_next;
  logic             accept;
  logic             last_entry;

  assign accept     = in_valid && in_ready;
  assign last_entry = (CNT_W'(CNT_W'(rd_i) + CNT_W'(1)) == stat.count);

  // Next state and commands
  always_comb begin
    state_next    = state;
    backward_next = backward;
    rd_i_next     = rd_i;
    in_ready      = 1'b0;
    cmd.exec      = 1'b0;
    cmd.mode      = in_mode;
    cmd.rd_load   = 1'b0;
    cmd.rd_last   = last_entry;
    cmd.rd_idx    = backward ? IDX_W'(stat.count - CNT_W'(1) - CNT_W'(rd_i)) : rd_i;
    unique case (state)
      ST_IDLE: begin
        in_ready = stat.slot_free;
        if (accept) begin
          unique case (in_mode) inside
            MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_REMOVE, MODE_CLEAR: begin
              cmd.exec = 1'b1;
            end
            MODE_READ_FWD, MODE_READ_BWD: begin
              // empty list answers at once with a single result
              if (stat.count == '0) begin
                cmd.exec = 1'b1;
              end else begin
                state_next    = ST_READ;
                backward_next = (in_mode == MODE_READ_BWD);
                rd_i_next     = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (stat.slot_free) begin
          cmd.rd_load = 1'b1;
          rd_i_next   = IDX_W'(rd_i + IDX_W'(1));
          if (last_entry) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      backward <= 1'b0;
      rd_i     <= '0;
    end else begin
      state    <= state_next;
      backward <= backward_next;
      rd_i     <= rd_i_next;
    end
  end

endmodule

@@ design/bold_dp.sv @@
// Datapath: cell chain, entry count and the registered output stage.
module bold_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  bold_pkg::cmd_t                cmd,
  input  logic [bold_pkg::VALUE_W-1:0]  value,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [bold_pkg::VALUE_W-1:0]  data_value,
  output logic                          is_last,
  output logic [bold_pkg::STATUS_W-1:0] status,
  output logic [bold_pkg::ENTRY_W-1:0]  entry_count,
  output bold_pkg::stat_t               stat
);
  import bold_pkg::*;

  logic [DATA_WIDTH-1:0] cells      [DEPTH];
  logic [DATA_WIDTH-1:0] cells_next [DEPTH];
  logic [CNT_W-1:0]      count, count_next;
  logic [DATA_WIDTH-1:0] v;
  logic [DEPTH-1:0]      match;
  logic [DEPTH-1:0]      kill;
  logic                  found;
  logic                  full;
  logic [STATUS_W-1:0]   res_status;
  logic                  slot_free;

  assign v         = to_cell(value);
  assign full      = (count == CNT_W'(DEPTH));
  assign slot_free = !out_valid || out_ready;
  assign found     = |match;

  assign stat.slot_free = slot_free;
  assign stat.count     = count;

  // Compare every valid cell against the search value
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (cells[i] == v) && (CNT_W'(i) < count);
    end
  end

  // Cells at and behind the first match close up the gap
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      kill[i] = |(match & ~({DEPTH{1'b1}} << (i + 1)));
    end
  end

  // Cell chain update for the single-step operations
  always_comb begin
    count_next = count;
    res_status = STAT_OK;
    for (int i = 0; i < DEPTH; i++) cells_next[i] = cells[i];
    if (cmd.exec) begin
      unique case (cmd.mode) inside
        MODE_PUSH_FRONT: begin
          if (full) begin
            res_status = STAT_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              cells_next[i] = (i == 0) ? v : cells[(i == 0) ? 0 : i - 1];
            end
            count_next = CNT_W'(count + CNT_W'(1));
          end
        end
        MODE_PUSH_BACK: begin
          if (full) begin
            res_status = STAT_FULL;
          end else begin
            cells_next[count[IDX_W-1:0]] = v;
            count_next = CNT_W'(count + CNT_W'(1));
          end
        end
        MODE_REMOVE: begin
          if (!found) begin
            res_status = STAT_NOT_FOUND;
          end else begin
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (kill[i]) cells_next[i] = cells[i + 1];
            end
            count_next = CNT_W'(count - CNT_W'(1));
          end
        end
        MODE_READ_FWD, MODE_READ_BWD: res_status = STAT_EMPTY;
        MODE_CLEAR:                   count_next = '0;
        default: ;
      endcase
    end
  end

  // Cell storage, no reset needed
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) cells[i] <= cells_next[i];
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else     count <= count_next;
  end

  // Output stage valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec || cmd.rd_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output stage payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      data_value  <= '0;
      is_last     <= 1'b1;
      status      <= res_status;
      entry_count <= ENTRY_W'(count_next);
    end else if (cmd.rd_load) begin
      data_value  <= from_cell(cells[cmd.rd_idx]);
      is_last     <= cmd.rd_last;
      status      <= STAT_OK;
      entry_count <= ENTRY_W'(count);
    end
  end

endmodule

@@ design/bounded_ordered_list_deque_unit.sv @@
// Top level of the bounded ordered list deque: controller, datapath and checks.
//
// Usage:
//   in_ch carries one operation per transfer (mode, value); out_ch returns
//   results (data_value, is_last, status, entry_count). Push front, push back,
//   remove-by-value and clear each update the cell chain and give one
//   result, visible on out_ch the cycle after the transfer. A read-out gives
//   one result per held entry, one per cycle while out_ch does not stall,
//   loaded into the output stage once the controller is in its read state;
//   in_ch is held off until the last entry is loaded. A read of an empty
//   list behaves like a single-result operation. Unused mode codes are taken
//   and dropped with no result. Throughput is one operation per cycle for
//   single-result operations while out_ch does not stall, set by the single
//   registered output stage which is freed in the same cycle its result is
//   taken.
//   Reset (rst, synchronous) empties the list and drops any pending result.
//   When out_ch stalls, the output stage holds its result and in_ch is not
//   ready until the cycle in which that result is taken.
module bounded_ordered_list_deque_unit (
  input  logic     clk,
  input  logic     rst,
  bold_in_if.sink  in_ch,
  bold_out_if.source out_ch
);
  import bold_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bold_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bold_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .value       (in_ch.value),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .data_value  (out_ch.data_value),
    .is_last     (out_ch.is_last),
    .status      (out_ch.status),
    .entry_count (out_ch.entry_count),
    .stat        (stat)
  );

  // Only one source may load the output stage in a cycle
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.exec && cmd.rd_load))
    else $error("operation and read-out loaded the output stage together");

  // Entry count never exceeds the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(DEPTH))
    else $error("entry count beyond capacity");

  // No new operation is taken while a read-out is running
  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_load |-> !in_ch.ready)
    else $error("input ready during read-out");

  // A taken operation shows its result in the next cycle
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_ch.valid && out_ch.is_last)
    else $error("operation result missing");

endmodule
